@@ sv/c8ic_pkg.sv @@
// shared types, instruction codes and the font table for the instruction core
// no dependencies
package c8ic_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int FRAME_BYTES   = (SCREEN_WIDTH / 8) * SCREEN_HEIGHT;
  localparam int FONT_BYTES    = 80;
  localparam logic [11:0] DEFAULT_START = 12'h200;

  typedef logic [11:0] addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  // item opcodes
  typedef enum logic [2:0] {
    OP_EXEC  = 3'd0,
    OP_TICK  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_DISP  = 3'd4
  } item_op_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_STACK = 2'd2,
    STAT_WAIT  = 2'd3
  } status_t;

  // instruction groups (top nibble)
  localparam logic [3:0] G_SYS   = 4'h0;
  localparam logic [3:0] G_JP    = 4'h1;
  localparam logic [3:0] G_CALL  = 4'h2;
  localparam logic [3:0] G_SEI   = 4'h3;
  localparam logic [3:0] G_SNEI  = 4'h4;
  localparam logic [3:0] G_SER   = 4'h5;
  localparam logic [3:0] G_LDI   = 4'h6;
  localparam logic [3:0] G_ADDI  = 4'h7;
  localparam logic [3:0] G_ALU   = 4'h8;
  localparam logic [3:0] G_SNER  = 4'h9;
  localparam logic [3:0] G_LDIDX = 4'hA;
  localparam logic [3:0] G_JPV0  = 4'hB;
  localparam logic [3:0] G_RND   = 4'hC;
  localparam logic [3:0] G_DRW   = 4'hD;
  localparam logic [3:0] G_KEY   = 4'hE;
  localparam logic [3:0] G_MISC  = 4'hF;

  localparam word_t INSN_CLS = 16'h00E0;
  localparam word_t INSN_RET = 16'h00EE;

  // alu sub-operations
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam byte_t KEY_SKP  = 8'h9E;
  localparam byte_t KEY_SKNP = 8'hA1;

  localparam byte_t F_GETDT = 8'h07;
  localparam byte_t F_WKEY  = 8'h0A;
  localparam byte_t F_SETDT = 8'h15;
  localparam byte_t F_SETST = 8'h18;
  localparam byte_t F_ADDI  = 8'h1E;
  localparam byte_t F_FONT  = 8'h29;
  localparam byte_t F_BCD   = 8'h33;
  localparam byte_t F_STORE = 8'h55;
  localparam byte_t F_LOAD  = 8'h65;

  localparam byte_t FONT_ROM [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // reset image of main memory: font at the bottom, zero above
  function automatic byte_t font_byte(addr_t a);
    byte_t b;
    b = 8'h00;
    if (a < addr_t'(FONT_BYTES)) begin
      b = FONT_ROM[a[6:0]];
    end
    return b;
  endfunction

endpackage

@@ sv/c8ic_if.sv @@
// channel interfaces of the instruction core: request, response, configuration
// no dependencies
interface c8ic_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [11:0] address;
  logic [7:0]  write_data;
  logic [15:0] keys_down;
  logic [7:0]  random_byte;
  logic        key_event_valid;
  logic [3:0]  key_event_code;
  modport source(output valid, opcode, address, write_data, keys_down, random_byte,
                 key_event_valid, key_event_code, input ready);
  modport sink(input valid, opcode, address, write_data, keys_down, random_byte,
               key_event_valid, key_event_code, output ready);
endinterface

interface c8ic_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] pc_now;
  logic [15:0] instruction_word;
  logic [7:0]  read_data;
  logic        display_changed;
  logic        sound_on;
  logic [1:0]  status;
  modport source(output valid, pc_now, instruction_word, read_data, display_changed,
                 sound_on, status, input ready);
  modport sink(input valid, pc_now, instruction_word, read_data, display_changed,
               sound_on, status, output ready);
endinterface

interface c8ic_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ sv/chip8_instruction_core_unit.sv @@
// instruction core: one sequencer around main memory, frame memory, register file
// and return stack; depends on c8ic_pkg and the interfaces in c8ic_if.sv
// a request beat is taken only in idle and answered by one response beat; a return and
// a flag write outside the result take a state of their own, a draw works through its
// sprite rows one by one, a clear walks every frame byte, bcd writes three digits and
// block store/load move one register at a time; one item at a time, bound by the single
// read port of main memory and of the register file. rst starts a pass over all of main
// memory that loads the font and clears memory, screen and registers before the first item
module chip8_instruction_core_unit #(
  parameter int STACK_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  c8ic_req_if.sink   req,
  c8ic_rsp_if.source rsp,
  c8ic_cfg_if.sink   cfg
);
  import c8ic_pkg::*;

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  typedef enum logic [22:0] {
    S_CLEAR  = 23'd1 << 0,
    S_IDLE   = 23'd1 << 1,
    S_MEMRD  = 23'd1 << 2,
    S_FETCH1 = 23'd1 << 3,
    S_FETCH2 = 23'd1 << 4,
    S_RDX    = 23'd1 << 5,
    S_RDY    = 23'd1 << 6,
    S_RD0    = 23'd1 << 7,
    S_EXEC   = 23'd1 << 8,
    S_WRF    = 23'd1 << 9,
    S_RET    = 23'd1 << 10,
    S_CLS    = 23'd1 << 11,
    S_BCD    = 23'd1 << 12,
    S_ST_RD  = 23'd1 << 13,
    S_ST_WR  = 23'd1 << 14,
    S_LD_RD  = 23'd1 << 15,
    S_LD_WR  = 23'd1 << 16,
    S_D_MEM  = 23'd1 << 17,
    S_D_F0   = 23'd1 << 18,
    S_D_W0   = 23'd1 << 19,
    S_D_W1   = 23'd1 << 20,
    S_D_END  = 23'd1 << 21,
    S_RESP   = 23'd1 << 22
  } state_t;

  // memories
  byte_t mem [MEM_BYTES];
  byte_t frame [FRAME_BYTES];
  byte_t vregs [16];
  addr_t stack_mem [STACK_DEPTH];

  byte_t mem_rdata, frm_rdata, reg_rdata;
  addr_t stk_rdata;
  logic  mem_we, frm_we, reg_we, stk_we;
  addr_t mem_waddr, mem_raddr;
  byte_t mem_wdata, frm_wdata, reg_wdata;
  logic [7:0] frm_waddr, frm_raddr;
  logic [3:0] reg_waddr, reg_raddr;
  logic [IDX_W-1:0] stk_waddr, stk_raddr;

  // control and architectural state
  state_t state, state_next;
  addr_t cnt;
  addr_t prog_counter, index_reg;
  logic [LVL_W-1:0] stack_level;
  byte_t delay_timer, sound_timer;

  // latched item
  item_op_t op_q;
  addr_t addr_q;
  logic [15:0] keys_q;
  byte_t rnd_q;
  logic kev_q;
  logic [3:0] kcode_q;

  // working registers
  word_t word;
  byte_t vx, vy, v0, sprite;
  logic hit, flag_q, drew;
  status_t status_q;
  byte_t rd_q;

  // result register
  logic out_valid;
  addr_t out_pc;
  word_t out_word;
  byte_t out_rd;
  logic out_drew, out_snd;
  status_t out_status;

  logic req_fire, cfg_fire, out_load;

  // instruction fields
  logic [3:0] f_x, f_y, f_n, f_top;
  byte_t f_nn;
  addr_t f_nnn, pc2, pc4;
  assign f_top = word[15:12];
  assign f_x   = word[11:8];
  assign f_y   = word[7:4];
  assign f_n   = word[3:0];
  assign f_nn  = word[7:0];
  assign f_nnn = word[11:0];
  assign pc2   = prog_counter + 12'd2;
  assign pc4   = prog_counter + 12'd4;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;
  assign out_load  = (state == S_RESP) && (!out_valid || rsp.ready);

  assign rsp.valid            = out_valid;
  assign rsp.pc_now           = out_pc;
  assign rsp.instruction_word = out_word;
  assign rsp.read_data        = out_rd;
  assign rsp.display_changed  = out_drew;
  assign rsp.sound_on         = out_snd;
  assign rsp.status           = out_status;

  // sprite placement with wrap
  logic [4:0] row_y;
  logic [2:0] col0, col1;
  logic [7:0] idx0, idx1;
  logic [15:0] spread;
  assign row_y  = vy[4:0] + {1'b0, cnt[3:0]};
  assign col0   = vx[5:3];
  assign col1   = col0 + 3'd1;
  assign idx0   = {row_y, col0};
  assign idx1   = {row_y, col1};
  assign spread = {sprite, 8'h00} >> vx[2:0];

  // bcd digits of vx
  logic [6:0] bcd_rem;
  logic [1:0] bcd_hun;
  logic [14:0] bcd_prod;
  logic [3:0] bcd_ten, bcd_one;
  byte_t bcd_digit;
  always_comb begin
    bcd_hun  = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
    bcd_rem  = 7'(vx - ((vx >= 8'd200) ? 8'd200 : ((vx >= 8'd100) ? 8'd100 : 8'd0)));
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_ten  = bcd_prod[14:11];
    bcd_one  = 4'(bcd_rem - 7'(bcd_ten) * 7'd10);
    unique case (cnt[1:0])
      2'd0:    bcd_digit = {6'd0, bcd_hun};
      2'd1:    bcd_digit = {4'd0, bcd_ten};
      default: bcd_digit = {4'd0, bcd_one};
    endcase
  end

  // instruction decode and execute
  addr_t ex_pc, ex_i;
  status_t ex_st;
  logic ex_wr, ex_fl_we, ex_fl, ex_i_we, ex_dt_we, ex_snd_we, ex_push, ex_pop, ex_draw;
  byte_t ex_val;
  state_t ex_next;
  logic [8:0] sum9;
  logic [12:0] sum13;
  logic key_down;
  always_comb begin
    ex_pc = pc2; ex_st = STAT_OK; ex_wr = 1'b0; ex_val = 8'h00;
    ex_fl_we = 1'b0; ex_fl = 1'b0; ex_i_we = 1'b0; ex_i = f_nnn;
    ex_dt_we = 1'b0; ex_snd_we = 1'b0; ex_push = 1'b0; ex_pop = 1'b0;
    ex_draw = 1'b0; ex_next = S_RESP;
    sum9  = {1'b0, vx} + {1'b0, vy};
    sum13 = {1'b0, index_reg} + {5'd0, vx};
    key_down = (vx[7:4] == 4'd0) && keys_q[vx[3:0]];
    unique case (f_top)
      G_SYS: begin
        if (word == INSN_CLS) begin
          ex_next = S_CLS; ex_draw = 1'b1;
        end else if (word == INSN_RET) begin
          if (stack_level == '0) begin
            ex_st = STAT_STACK; ex_pc = prog_counter;
          end else begin
            ex_pop = 1'b1; ex_next = S_RET;
          end
        end
      end
      G_JP: ex_pc = f_nnn;
      G_CALL: begin
        if (stack_level >= LVL_W'(STACK_DEPTH)) begin
          ex_st = STAT_STACK; ex_pc = prog_counter;
        end else begin
          ex_push = 1'b1; ex_pc = f_nnn;
        end
      end
      G_SEI:  if (vx == f_nn) ex_pc = pc4;
      G_SNEI: if (vx != f_nn) ex_pc = pc4;
      G_SER:  if (vx == vy) ex_pc = pc4;
      G_SNER: if (vx != vy) ex_pc = pc4;
      G_LDI:  begin ex_wr = 1'b1; ex_val = f_nn; end
      G_ADDI: begin ex_wr = 1'b1; ex_val = vx + f_nn; end
      G_ALU: begin
        unique case (f_n)
          ALU_MOV: begin ex_wr = 1'b1; ex_val = vy; end
          ALU_OR:  begin ex_wr = 1'b1; ex_val = vx | vy; end
          ALU_AND: begin ex_wr = 1'b1; ex_val = vx & vy; end
          ALU_XOR: begin ex_wr = 1'b1; ex_val = vx ^ vy; end
          ALU_ADD: begin
            ex_wr = 1'b1; ex_val = sum9[7:0]; ex_fl_we = 1'b1; ex_fl = sum9[8];
          end
          ALU_SUB: begin
            ex_wr = 1'b1; ex_val = vx - vy; ex_fl_we = 1'b1; ex_fl = (vx >= vy);
          end
          ALU_SHR: begin
            ex_wr = 1'b1; ex_val = {1'b0, vx[7:1]}; ex_fl_we = 1'b1; ex_fl = vx[0];
          end
          ALU_RSB: begin
            ex_wr = 1'b1; ex_val = vy - vx; ex_fl_we = 1'b1; ex_fl = (vy >= vx);
          end
          ALU_SHL: begin
            ex_wr = 1'b1; ex_val = {vx[6:0], 1'b0}; ex_fl_we = 1'b1; ex_fl = vx[7];
          end
          default: begin ex_st = STAT_BAD; ex_pc = prog_counter; end
        endcase
      end
      G_LDIDX: begin ex_i_we = 1'b1; ex_i = f_nnn; end
      G_JPV0:  ex_pc = f_nnn + {4'd0, v0};
      G_RND:   begin ex_wr = 1'b1; ex_val = rnd_q & f_nn; end
      G_DRW: begin
        ex_draw = 1'b1;
        ex_next = (f_n == 4'd0) ? S_D_END : S_D_MEM;
      end
      G_KEY: begin
        if (f_nn == KEY_SKP) begin
          if (key_down) ex_pc = pc4;
        end else if (f_nn == KEY_SKNP) begin
          if (!key_down) ex_pc = pc4;
        end else begin
          ex_st = STAT_BAD; ex_pc = prog_counter;
        end
      end
      default: begin
        unique case (f_nn)
          F_GETDT: begin ex_wr = 1'b1; ex_val = delay_timer; end
          F_WKEY: begin
            if (!kev_q) begin
              ex_st = STAT_WAIT; ex_pc = prog_counter;
            end else begin
              ex_wr = 1'b1; ex_val = {4'd0, kcode_q};
            end
          end
          F_SETDT: ex_dt_we = 1'b1;
          F_SETST: ex_snd_we = 1'b1;
          F_ADDI: begin
            ex_i_we = 1'b1; ex_i = sum13[11:0]; ex_fl_we = 1'b1; ex_fl = sum13[12];
          end
          F_FONT: begin ex_i_we = 1'b1; ex_i = {2'd0, vx, 2'd0} + {4'd0, vx}; end
          F_BCD:   ex_next = S_BCD;
          F_STORE: ex_next = S_ST_RD;
          F_LOAD:  ex_next = S_LD_RD;
          default: begin ex_st = STAT_BAD; ex_pc = prog_counter; end
        endcase
      end
    endcase
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0; mem_waddr = index_reg + cnt; mem_wdata = 8'h00; mem_raddr = prog_counter;
    frm_we = 1'b0; frm_waddr = idx0; frm_wdata = 8'h00; frm_raddr = idx0;
    reg_we = 1'b0; reg_waddr = f_x; reg_wdata = ex_val; reg_raddr = f_x;
    stk_we = 1'b0;
    stk_waddr = stack_level[IDX_W-1:0];
    stk_raddr = IDX_W'(stack_level - LVL_W'(1));
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1; mem_waddr = cnt; mem_wdata = font_byte(cnt);
        frm_we = 1'b1; frm_waddr = cnt[7:0];
        reg_we = 1'b1; reg_waddr = cnt[3:0]; reg_wdata = 8'h00;
      end
      S_IDLE: begin
        if (item_op_t'(req.opcode) == OP_READ) mem_raddr = req.address;
        frm_raddr = req.address[7:0];
        if (req_fire && item_op_t'(req.opcode) == OP_WRITE) begin
          mem_we = 1'b1; mem_waddr = req.address; mem_wdata = req.write_data;
        end
      end
      S_FETCH1: mem_raddr = pc2 - 12'd1;
      S_RDX:    reg_raddr = f_y;
      S_RDY:    reg_raddr = 4'd0;
      S_EXEC: begin
        reg_we = ex_wr;
        stk_we = ex_push;
      end
      S_WRF: begin reg_we = 1'b1; reg_waddr = 4'hF; reg_wdata = {7'd0, flag_q}; end
      S_CLS: begin frm_we = 1'b1; frm_waddr = cnt[7:0]; end
      S_BCD: begin mem_we = 1'b1; mem_wdata = bcd_digit; end
      S_ST_RD: reg_raddr = cnt[3:0];
      S_ST_WR: begin mem_we = 1'b1; mem_wdata = reg_rdata; end
      S_LD_RD: mem_raddr = index_reg + cnt;
      S_LD_WR: begin reg_we = 1'b1; reg_waddr = cnt[3:0]; reg_wdata = mem_rdata; end
      S_D_MEM: mem_raddr = index_reg + cnt;
      S_D_W0: begin
        frm_we = 1'b1; frm_waddr = idx0; frm_wdata = frm_rdata ^ spread[15:8];
        frm_raddr = idx1;
      end
      S_D_W1: begin
        frm_we = 1'b1; frm_waddr = idx1; frm_wdata = frm_rdata ^ spread[7:0];
      end
      S_D_END: begin reg_we = 1'b1; reg_waddr = 4'hF; reg_wdata = {7'd0, hit}; end
      default: ;
    endcase
  end

  // memory arrays, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
    if (frm_we) frame[frm_waddr] <= frm_wdata;
    frm_rdata <= frame[frm_raddr];
    if (reg_we) vregs[reg_waddr] <= reg_wdata;
    reg_rdata <= vregs[reg_raddr];
    if (stk_we) stack_mem[stk_waddr] <= prog_counter;
    stk_rdata <= stack_mem[stk_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (cnt == addr_t'(MEM_BYTES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (req_fire) begin
          unique case (item_op_t'(req.opcode))
            OP_EXEC:         state_next = S_FETCH1;
            OP_READ, OP_DISP: state_next = S_MEMRD;
            default:         state_next = S_RESP;
          endcase
        end
      end
      S_MEMRD:  state_next = S_RESP;
      S_FETCH1: state_next = S_FETCH2;
      S_FETCH2: state_next = S_RDX;
      S_RDX:    state_next = S_RDY;
      S_RDY:    state_next = S_RD0;
      S_RD0:    state_next = S_EXEC;
      // flag goes in its own state (S_WRF) unless the result itself lands in vf
      S_EXEC:   state_next = (ex_fl_we && !(ex_wr && f_x == 4'hF)) ? S_WRF : ex_next;
      S_WRF:    state_next = S_RESP;
      S_RET:    state_next = S_RESP;
      S_CLS:    if (cnt[7:0] == 8'hFF) state_next = S_RESP;
      S_BCD:    if (cnt[1:0] == 2'd2) state_next = S_RESP;
      S_ST_RD:  state_next = S_ST_WR;
      S_ST_WR:  state_next = (cnt[3:0] == f_x) ? S_RESP : S_ST_RD;
      S_LD_RD:  state_next = S_LD_WR;
      S_LD_WR:  state_next = (cnt[3:0] == f_x) ? S_RESP : S_LD_RD;
      S_D_MEM:  state_next = S_D_F0;
      S_D_F0:   state_next = S_D_W0;
      S_D_W0:   state_next = S_D_W1;
      S_D_W1:   state_next = (cnt[3:0] == f_n - 4'd1) ? S_D_END : S_D_MEM;
      S_D_END:  state_next = S_RESP;
      S_RESP:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      prog_counter <= DEFAULT_START;
      index_reg    <= '0;
      stack_level  <= '0;
      delay_timer  <= '0;
      sound_timer  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: cnt <= cnt + 12'd1;
        S_IDLE: begin
          cnt <= '0;
          if (req_fire && item_op_t'(req.opcode) == OP_TICK) begin
            if (delay_timer != 8'd0) delay_timer <= delay_timer - 8'd1;
            if (sound_timer != 8'd0) sound_timer <= sound_timer - 8'd1;
          end
        end
        S_EXEC: begin
          prog_counter <= ex_pc;
          if (ex_i_we) index_reg <= ex_i;
          if (ex_dt_we) delay_timer <= vx;
          if (ex_snd_we) sound_timer <= vx;
          if (ex_push) stack_level <= stack_level + LVL_W'(1);
          if (ex_pop) stack_level <= stack_level - LVL_W'(1);
        end
        S_RET: prog_counter <= stk_rdata + 12'd2;
        S_CLS, S_BCD, S_ST_WR, S_LD_WR, S_D_W1: cnt <= cnt + 12'd1;
        default: ;
      endcase
      if (cfg_fire) prog_counter <= cfg.data;
    end
  end

  // item and working registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_q     <= item_op_t'(req.opcode);
        addr_q   <= req.address;
        keys_q   <= req.keys_down;
        rnd_q    <= req.random_byte;
        kev_q    <= req.key_event_valid;
        kcode_q  <= req.key_event_code;
        word     <= '0;
        rd_q     <= '0;
        drew     <= 1'b0;
        status_q <= STAT_OK;
      end
      S_MEMRD: begin
        if (op_q == OP_READ) rd_q <= mem_rdata;
        else if (addr_q[11:8] == 4'd0) rd_q <= frm_rdata;
      end
      S_FETCH1: word[15:8] <= mem_rdata;
      S_FETCH2: word[7:0]  <= mem_rdata;
      S_RDX: vx <= reg_rdata;
      S_RDY: vy <= reg_rdata;
      S_RD0: v0 <= reg_rdata;
      S_EXEC: begin
        status_q <= ex_st;
        drew     <= ex_draw;
        flag_q   <= ex_fl;
        hit      <= 1'b0;
      end
      S_D_F0: sprite <= mem_rdata;
      S_D_W0: hit <= hit | (|(frm_rdata & spread[15:8]));
      S_D_W1: hit <= hit | (|(frm_rdata & spread[7:0]));
      default: ;
    endcase
    if (out_load) begin
      out_pc     <= prog_counter;
      out_word   <= word;
      out_rd     <= rd_q;
      out_drew   <= drew;
      out_snd    <= (sound_timer != 8'd0);
      out_status <= status_q;
    end
  end

endmodule

@@ test/c8ic_check.sv @@
// checker for the instruction core: predicts each response beat from accepted requests
// depends on c8ic_pkg and the channel interfaces in c8ic_if.sv
module c8ic_check (
  input  logic clk,
  input  logic rst,
  c8ic_req_if  req,
  c8ic_rsp_if  rsp,
  c8ic_cfg_if  cfg,
  output int   fail_count,
  output int   pending,
  output int   beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import c8ic_pkg::*;

  typedef struct packed {
    addr_t      pc;
    word_t      insn;
    byte_t      rdata;
    logic       drew;
    logic       snd;
    logic [1:0] stat;
  } resp_t;

  // machine copy
  byte_t mem [MEM_BYTES];
  byte_t vreg [16];
  addr_t stk [16];
  int    depth;
  addr_t pc, idx;
  byte_t dtimer, stimer;
  byte_t frame [FRAME_BYTES];
  resp_t want_q [$];

  task automatic report(string what, logic [31:0] got, logic [31:0] exp);
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, exp);
    fail_count++;
  endtask

  // run one instruction word, return status
  function automatic logic [1:0] run_word(word_t w, logic [15:0] keys, byte_t rnd,
                                          logic kev, logic [3:0] kcode, output logic drew);
    logic [3:0] top, x, y, n;
    byte_t nn, vx, vy;
    addr_t nnn, nxt;
    logic [8:0] sum;
    logic hit, down;
    byte_t bits;
    int px, py, bi;
    logic [12:0] s13;
    top = w[15:12]; x = w[11:8]; y = w[7:4]; n = w[3:0]; nn = w[7:0]; nnn = w[11:0];
    vx = vreg[x]; vy = vreg[y]; nxt = pc + 12'd2; drew = 0;
    case (top)
      G_SYS: begin
        if (w == INSN_CLS) begin
          foreach (frame[k]) frame[k] = 0;
          drew = 1;
        end else if (w == INSN_RET) begin
          if (depth == 0) return STAT_STACK;
          depth--;
          nxt = stk[depth] + 12'd2;
        end
      end
      G_CALL: begin
        if (depth >= 16) return STAT_STACK;
        stk[depth] = pc; depth++; nxt = nnn;
      end
      G_JP: nxt = nnn;
      G_SEI: if (vx == nn) nxt = pc + 12'd4;
      G_SNEI: if (vx != nn) nxt = pc + 12'd4;
      G_SER: if (vx == vy) nxt = pc + 12'd4;
      G_SNER: if (vx != vy) nxt = pc + 12'd4;
      G_LDI: vreg[x] = nn;
      G_ADDI: vreg[x] = vx + nn;
      G_ALU: begin
        case (n)
          ALU_MOV: vreg[x] = vy;
          ALU_OR:  vreg[x] = vx | vy;
          ALU_AND: vreg[x] = vx & vy;
          ALU_XOR: vreg[x] = vx ^ vy;
          ALU_ADD: begin sum = vx + vy; vreg[15] = sum[8]; vreg[x] = sum[7:0]; end
          ALU_SUB: begin vreg[15] = vx >= vy; vreg[x] = vx - vy; end
          ALU_SHR: begin vreg[15] = vx[0]; vreg[x] = vx >> 1; end
          ALU_RSB: begin vreg[15] = vy >= vx; vreg[x] = vy - vx; end
          ALU_SHL: begin vreg[15] = vx[7]; vreg[x] = vx << 1; end
          default: return STAT_BAD;
        endcase
      end
      G_LDIDX: idx = nnn;
      G_JPV0: nxt = nnn + addr_t'(vreg[0]);
      G_RND: vreg[x] = rnd & nn;
      G_DRW: begin
        hit = 0;
        for (int r = 0; r < n; r++) begin
          bits = mem[addr_t'(idx + r)];
          for (int c = 0; c < 8; c++) if (bits[7-c]) begin
            px = (vx + c) % 64; py = (vy + r) % 32; bi = py * 8 + px / 8;
            if (frame[bi][7 - px % 8]) hit = 1;
            frame[bi][7 - px % 8] ^= 1'b1;
          end
        end
        vreg[15] = hit; drew = 1;
      end
      G_KEY: begin
        down = vx < 16 && keys[vx[3:0]];
        if (nn == KEY_SKP) begin if (down) nxt = pc + 12'd4; end
        else if (nn == KEY_SKNP) begin if (!down) nxt = pc + 12'd4; end
        else return STAT_BAD;
      end
      default: begin
        case (nn)
          F_GETDT: vreg[x] = dtimer;
          F_WKEY: begin
            if (!kev) return STAT_WAIT;
            vreg[x] = kcode;
          end
          F_SETDT: dtimer = vx;
          F_SETST: stimer = vx;
          F_ADDI: begin s13 = idx + vx; vreg[15] = s13[12]; idx = s13[11:0]; end
          F_FONT: idx = addr_t'(vx * 5);
          F_BCD: begin
            mem[idx] = vx / 100; mem[addr_t'(idx + 1)] = (vx / 10) % 10;
            mem[addr_t'(idx + 2)] = vx % 10;
          end
          F_STORE: for (int i = 0; i <= x; i++) mem[addr_t'(idx + i)] = vreg[i];
          F_LOAD:  for (int i = 0; i <= x; i++) vreg[i] = mem[addr_t'(idx + i)];
          default: return STAT_BAD;
        endcase
      end
    endcase
    pc = nxt;
    return STAT_OK;
  endfunction

  // reset image, configuration and request beats
  always @(posedge clk) begin
    resp_t e;
    logic d;
    if (rst) begin
      foreach (mem[k]) mem[k] = (k < FONT_BYTES) ? FONT_ROM[k] : 8'h00;
      foreach (vreg[k]) vreg[k] = 0;
      foreach (frame[k]) frame[k] = 0;
      foreach (stk[k]) stk[k] = 0;
      depth = 0; pc = DEFAULT_START; idx = 0; dtimer = 0; stimer = 0;
      want_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) pc = cfg.data;
      if (req.valid && req.ready) begin
        e = '0;
        case (req.opcode)
          OP_EXEC: begin
            e.insn = {mem[pc], mem[addr_t'(pc + 1)]};
            e.stat = run_word(e.insn, req.keys_down, req.random_byte,
                              req.key_event_valid, req.key_event_code, d);
            e.drew = d;
          end
          OP_TICK: begin
            if (dtimer != 0) dtimer--;
            if (stimer != 0) stimer--;
          end
          OP_WRITE: mem[req.address] = req.write_data;
          OP_READ: e.rdata = mem[req.address];
          OP_DISP: if (req.address < FRAME_BYTES) e.rdata = frame[req.address];
          default: ;
        endcase
        e.pc = pc; e.snd = stimer != 0;
        want_q.push_back(e);
      end
    end
  end

  // response beats
  always @(posedge clk) begin
    resp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      beats_seen++;
      if (want_q.size() == 0) report("unexpected beat", 0, 0);
      else begin
        e = want_q.pop_front();
        if (rsp.pc_now !== e.pc) report("pc_now", rsp.pc_now, e.pc);
        if (rsp.instruction_word !== e.insn)
          report("instruction_word", rsp.instruction_word, e.insn);
        if (rsp.read_data !== e.rdata) report("read_data", rsp.read_data, e.rdata);
        if (rsp.display_changed !== e.drew)
          report("display_changed", rsp.display_changed, e.drew);
        if (rsp.sound_on !== e.snd) report("sound_on", rsp.sound_on, e.snd);
        if (rsp.status !== e.stat) report("status", rsp.status, e.stat);
      end
    end
  end

  // outstanding beats, registered copy of the queue size
  always @(posedge clk) pending <= want_q.size();

  initial begin
    fail_count = 0;
    beats_seen = 0;
  end
endmodule

@@ test/chip8_instruction_core_unit_tb.sv @@
// stimulus and verdict for the instruction core: loads small programs and runs them
// depends on c8ic_pkg, c8ic_if.sv, c8ic_check.sv and the core itself
module chip8_instruction_core_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c8ic_pkg::*;

  logic clk, rst;
  int   fails, pending, seen, cycles;
  bit   long_hold;

  c8ic_req_if req ();
  c8ic_rsp_if rsp ();
  c8ic_cfg_if cfg ();

  chip8_instruction_core_unit i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));
  c8ic_check i_check (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                      .fail_count(fails), .pending(pending), .beats_seen(seen));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("chip8_instruction_core_unit: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int w;
    rsp.ready <= 0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        rsp.ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        rsp.ready <= 0;
        repeat (w) @(posedge clk);
      end
      rsp.ready <= 1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  // valid stays up after the beat so that a following send can go back to back
  task automatic send(logic [2:0] op, addr_t a, byte_t wd = '0, logic [15:0] keys = '0,
                      byte_t rnd = '0, logic kv = 1'b0, logic [3:0] kc = '0, bit gaps = 1);
    int w;
    w = gaps ? $urandom_range(0, 16) : 0;
    if (w > 0) begin
      req.valid <= 0;
      repeat (w) @(posedge clk);
    end
    req.valid <= 1; req.opcode <= op; req.address <= a; req.write_data <= wd;
    req.keys_down <= keys; req.random_byte <= rnd; req.key_event_valid <= kv;
    req.key_event_code <= kc;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic exec_rand();
    send(OP_EXEC, addr_t'($urandom), byte_t'($urandom), 16'($urandom), byte_t'($urandom),
         1'($urandom_range(0, 1)), 4'($urandom));
  endtask

  task automatic store_word(addr_t a, word_t w);
    send(OP_WRITE, a, w[15:8]);
    send(OP_WRITE, a + 12'd1, w[7:0]);
  endtask

  task automatic set_start(addr_t s);
    req.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    cfg.valid <= 1; cfg.data <= s;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
  endtask

  // random instruction biased to valid encodings; a return only when lvl is above zero
  function automatic word_t pick_word(int lvl);
    word_t w;
    w = word_t'($urandom);
    case ($urandom_range(0, 13))
      0: w = INSN_CLS;
      1: w = (lvl > 0) ? INSN_RET : {G_LDI, w[11:0]};
      2: w = {G_ALU, w[11:4], 4'($urandom_range(0, 7))};
      3: w = {G_ALU, w[11:4], ALU_SHL};
      4: w = {G_DRW, w[11:4], 4'($urandom_range(0, 5))};
      5: w = {G_KEY, w[11:8], ($urandom_range(0, 1) ? KEY_SKP : KEY_SKNP)};
      6: begin
        byte_t f [9] = '{F_GETDT, F_WKEY, F_SETDT, F_SETST, F_ADDI, F_FONT, F_BCD,
                         F_STORE, F_LOAD};
        w = {G_MISC, w[11:8], f[$urandom_range(0, 8)]};
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    addr_t base;
    int    lvl;
    word_t w;
    rst = 1;
    req.valid = 0; req.opcode = 0; req.address = 0; req.write_data = 0; req.keys_down = 0;
    req.random_byte = 0; req.key_event_valid = 0; req.key_event_code = 0;
    cfg.valid = 0; cfg.data = 0;
    long_hold = 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: reads, display, faults, wait for key, subtract, wrap
    send(OP_READ, 12'd0);
    send(OP_READ, 12'hFFF);
    send(OP_DISP, 12'd300);
    send(OP_EXEC, 12'd0);                      // 0000 machine call
    store_word(12'h202, INSN_RET);             // return on empty stack
    send(OP_EXEC, 12'd0);
    store_word(12'h202, 16'h8FFF);             // unknown alu
    send(OP_EXEC, 12'd0);
    store_word(12'h202, 16'h6AFF);
    send(OP_EXEC, 12'd0);
    store_word(12'h204, 16'h8AA5);             // equal subtract sets flag
    send(OP_EXEC, 12'd0);
    store_word(12'h206, 16'hF30A);             // wait for key
    send(OP_EXEC, 12'd0);
    send(OP_EXEC, 12'd0, 8'd0, 16'hFFFF, 8'hFF, 1'b1, 4'hF);
    send(OP_TICK, 12'd0);
    send(OP_WRITE, 12'hFFF, 8'hFF);
    send(OP_DISP, 12'd255);

    // program start extremes
    set_start(12'hFFF);
    send(OP_EXEC, 12'd0);
    set_start(12'h000);
    send(OP_EXEC, 12'd0, 8'd0, 16'hFFFF, 8'hFF, 1'b1, 4'hF, 0);

    // random programs: load words, then execute; some noise items in between
    for (int blk = 0; blk < 30; blk++) begin
      base = 12'($urandom_range(0, 2047) * 2);
      set_start(blk == 15 ? 12'hFFE : base);
      if (blk == 15) base = 12'hFFE;
      lvl = 0;
      for (int k = 0; k < 6; k++) begin
        w = pick_word(lvl);
        store_word(base + 12'(2 * k), w);
      end
      if (blk == 5) long_hold = 1;
      for (int k = 0; k < 9; k++) begin
        case ($urandom_range(0, 9))
          0: send(OP_TICK, 12'd0);
          1: send(OP_DISP, 12'($urandom_range(0, 300)));
          2: send(OP_READ, addr_t'($urandom));
          3: send(OP_WRITE, addr_t'($urandom), byte_t'($urandom));
          4: send(3'($urandom_range(5, 7)), addr_t'($urandom));
          default: exec_rand();
        endcase
      end
    end

    req.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    $display("covered %0d response beats over 32 program loads and start settings", seen);
    if (fails == 0) $display("chip8_instruction_core_unit: match");
    else $display("chip8_instruction_core_unit: mismatch");
    $finish;
  end
endmodule
